// ----- hw/rtl/eplat_pkg.sv -----
// shared types and constants for the exclusion process lattice step block
// item structs, kind and register codes, sequencer states, saturating increment
// no dependencies
package eplat_pkg;

   localparam int SITES     = 128;
   localparam int SITE_W    = $clog2(SITES);
   localparam int MID_SITE  = SITES / 2 - 1;
   localparam int LAST_SITE = SITES - 1;
   localparam int THR_W     = 16;
   localparam int CNT_W     = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] KIND_ATTEMPT = 2'd0;
   localparam logic [1:0] KIND_SAMPLE  = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ENTRY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOP   = 2'd2;

   localparam logic [THR_W-1:0] HOP_THR_RESET = 16'd655;

   typedef struct packed {
      logic [1:0]       kind;
      logic [6:0]       site_index;
      logic [THR_W-1:0] draw_first;
      logic [THR_W-1:0] draw_second;
      logic             measuring;
   } req_item_type;

   typedef struct packed {
      logic             entered;
      logic             exited;
      logic             hopped;
      logic             site_occupied;
      logic [CNT_W-1:0] current_count;
      logic [CNT_W-1:0] density_value;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ATTEMPT,
      ST_SWEEP_RD,
      ST_SWEEP_WR,
      ST_READ,
      ST_RESP
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

endpackage

// ----- hw/rtl/exclusion_process_lattice_step.sv -----
// exclusion process lattice: occupancy bits, per-site density counters, crossing count
// one sequencer around a single shared saturating incrementer and a density memory
// depends on eplat_pkg
//
//  channel   ports                         handshake
//  -------   ---------------------------   ------------------------------------
//  request   start, busy, req_item         taken when start high and busy low
//  result    rsp_valid, rsp_item           one-cycle strobe, cannot be held off
//  config    csr_valid, csr_ready,         written when csr_valid and csr_ready
//            csr_index, csr_data           (csr_ready is always high)
//
// attempt and read items pass through ST_ATTEMPT or ST_READ before the result
// strobe in ST_RESP, unused-kind items go straight to it; sample items walk
// the density memory through its single port, a read and a write state per
// site, before the strobe; busy stays high until the cycle after the strobe
// reset is synchronous; density entries carry valid bits cleared by reset, so
// there is no clearing pass and the block takes items right after reset
module exclusion_process_lattice_step
   import eplat_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   output rsp_item_type         rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_data
);

   // control and lattice state
   state_type          state_ff, state_in;
   req_item_type       req_ff, req_in;
   logic [SITES-1:0]   occ_ff, occ_in;
   logic [SITES-1:0]   dvld_ff, dvld_in;
   logic [CNT_W-1:0]   crossing_ff, crossing_in;
   logic [SITE_W-1:0]  ctr_ff, ctr_in;
   logic               ent_ff, ent_in;
   logic               ext_ff, ext_in;
   logic               hop_ff, hop_in;

   // thresholds
   logic [THR_W-1:0]   entry_thr_ff, exit_thr_ff, hop_thr_ff;

   // density memory, single port, registered read
   logic [CNT_W-1:0]   dens_mem [SITES];
   logic [CNT_W-1:0]   rd_data_ff;
   logic [SITE_W-1:0]  mem_addr;
   logic               mem_we;

   // the shared saturating incrementer
   logic [CNT_W-1:0]   inc_operand;
   logic [CNT_W-1:0]   inc_result;

   // attempt decode
   logic [SITE_W-1:0]  s_idx;
   logic [SITE_W-1:0]  s_next;
   logic               site_ok;
   logic               at_first, at_last;
   logic               occ_s, occ_n, occ_s_ent;
   logic               first_used;
   logic [THR_W-1:0]   hop_draw;
   logic               ent_c, ext_c, hop_c;
   logic               dens_ok;

   assign csr_ready  = 1'b1;
   assign busy       = (state_ff != ST_IDLE);
   assign inc_result = sat_inc(inc_operand);

   assign s_idx    = SITE_W'(req_ff.site_index);
   assign s_next   = s_idx + SITE_W'(1);
   assign site_ok  = (32'(req_ff.site_index) < 32'(SITES));
   assign at_first = (32'(s_idx) == 32'(0));
   assign at_last  = (32'(s_idx) == 32'(LAST_SITE));
   assign occ_s    = occ_ff[s_idx];
   assign occ_n    = at_last ? 1'b1 : occ_ff[s_next];

   // entry at site zero uses up draw_first, a following hop then takes draw_second
   assign first_used = at_first && !occ_s;
   assign ent_c      = first_used && (req_ff.draw_first <= entry_thr_ff);
   assign occ_s_ent  = occ_s || ent_c;
   assign ext_c      = at_last && occ_s_ent && (req_ff.draw_first <= exit_thr_ff);
   assign hop_draw   = first_used ? req_ff.draw_second : req_ff.draw_first;
   assign hop_c      = !at_last && occ_s_ent && !occ_n && (hop_draw <= hop_thr_ff);

   assign dens_ok = (req_ff.kind == KIND_READ) && site_ok && dvld_ff[s_idx];

   // result fields come straight from registers during the strobe cycle
   always_comb begin
      rsp_valid                = (state_ff == ST_RESP);
      rsp_item.entered         = ent_ff;
      rsp_item.exited          = ext_ff;
      rsp_item.hopped          = hop_ff;
      rsp_item.site_occupied   = site_ok && occ_ff[s_idx];
      rsp_item.current_count   = crossing_ff;
      rsp_item.density_value   = dens_ok ? rd_data_ff : '0;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      occ_in      = occ_ff;
      dvld_in     = dvld_ff;
      crossing_in = crossing_ff;
      ctr_in      = ctr_ff;
      ent_in      = ent_ff;
      ext_in      = ext_ff;
      hop_in      = hop_ff;
      mem_addr    = s_idx;
      mem_we      = 1'b0;
      inc_operand = crossing_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               ent_in = 1'b0;
               ext_in = 1'b0;
               hop_in = 1'b0;
               ctr_in = '0;
               case (req_item.kind)
                  KIND_ATTEMPT: state_in = (32'(req_item.site_index) < 32'(SITES))
                                         ? ST_ATTEMPT : ST_RESP;
                  KIND_SAMPLE:  state_in = ST_SWEEP_RD;
                  KIND_READ:    state_in = ST_READ;
                  default:      state_in = ST_RESP;
               endcase
            end
         end
         ST_ATTEMPT: begin
            // incrementer serves the crossing count here
            inc_operand = crossing_ff;
            ent_in      = ent_c;
            ext_in      = ext_c;
            hop_in      = hop_c;
            if (ent_c) occ_in[s_idx] = 1'b1;
            if (ext_c) occ_in[s_idx] = 1'b0;
            if (hop_c) begin
               occ_in[s_idx]  = 1'b0;
               occ_in[s_next] = 1'b1;
               if ((32'(s_idx) == 32'(MID_SITE)) && req_ff.measuring) begin
                  crossing_in = inc_result;
               end
            end
            state_in = ST_RESP;
         end
         ST_SWEEP_RD: begin
            mem_addr = ctr_ff;
            state_in = ST_SWEEP_WR;
         end
         ST_SWEEP_WR: begin
            // incrementer serves the density counter of the current site
            mem_addr    = ctr_ff;
            inc_operand = dvld_ff[ctr_ff] ? rd_data_ff : '0;
            if (occ_ff[ctr_ff]) begin
               mem_we          = 1'b1;
               dvld_in[ctr_ff] = 1'b1;
            end
            ctr_in = ctr_ff + SITE_W'(1);
            if (32'(ctr_ff) == 32'(LAST_SITE)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SWEEP_RD;
            end
         end
         ST_READ: begin
            mem_addr = s_idx;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         dvld_ff      <= '0;
         crossing_ff  <= '0;
         ctr_ff       <= '0;
         ent_ff       <= 1'b0;
         ext_ff       <= 1'b0;
         hop_ff       <= 1'b0;
         entry_thr_ff <= '0;
         exit_thr_ff  <= '0;
         hop_thr_ff   <= HOP_THR_RESET;
      end else begin
         state_ff    <= state_in;
         occ_ff      <= occ_in;
         dvld_ff     <= dvld_in;
         crossing_ff <= crossing_in;
         ctr_ff      <= ctr_in;
         ent_ff      <= ent_in;
         ext_ff      <= ext_in;
         hop_ff      <= hop_in;
         // unused index is dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ENTRY: entry_thr_ff <= csr_data;
               REG_EXIT:  exit_thr_ff  <= csr_data;
               REG_HOP:   hop_thr_ff   <= csr_data;
               default:   ;
            endcase
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // density memory port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dens_mem[mem_addr] <= inc_result;
      end
      rd_data_ff <= dens_mem[mem_addr];
   end

endmodule

// ----- hw/rtl/eplat_checker.sv -----
// port-level checks for the exclusion process lattice step block
// bound to the top level; depends on eplat_pkg
module eplat_checker
   import eplat_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   // an accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // a result only shows while an item is in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // one strobe per item, and the block frees up right after it
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe not followed by idle");

   // entry and exit touch different ends of the lattice
   a_ent_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.entered && rsp_item.exited))
      else $error("entry and exit on one item");

   // the crossing count never goes down between results
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.current_count >= $past(rsp_item.current_count)))
      else $error("crossing count went down");

endmodule

bind exclusion_process_lattice_step eplat_checker u_eplat_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
